// ===== rtl/tcc_pkg.sv =====
`timescale 1ns / 1ps
package tcc_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Operation token, first character in the low byte
  localparam logic [23:0] OPS_ADD = 24'h646461;
  localparam logic [23:0] OPS_SUB = 24'h627573;
  localparam logic [23:0] OPS_MUL = 24'h6c756d;
  localparam logic [23:0] OPS_DIV = 24'h766964;

  localparam logic [1:0] OP_CHARS_FULL = 2'd3;
  localparam logic [1:0] TOKEN_LAST    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_OP   = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_BAD = 3'd4
  } op_t;

  function automatic op_t decode_op(logic [1:0] count, logic [23:0] chars);
    op_t op;
    op = OP_BAD;
    if (count == OP_CHARS_FULL) begin
      if (chars == OPS_ADD) op = OP_ADD;
      else if (chars == OPS_SUB) op = OP_SUB;
      else if (chars == OPS_MUL) op = OP_MUL;
      else if (chars == OPS_DIV) op = OP_DIV;
    end
    return op;
  endfunction

endpackage

// ===== rtl/tcc_ifs.sv =====
`timescale 1ns / 1ps
interface tcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_line;

  modport source (output valid, output char_byte, output end_of_line, input ready);
  modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface

interface tcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] answer;
  logic        [1:0]  status;

  modport source (output valid, output answer, output status, input ready);
  modport sink   (input valid, input answer, input status, output ready);
endinterface

// ===== rtl/tcc_front.sv =====
`timescale 1ns / 1ps
module tcc_front
  import tcc_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_char_byte,
  input  logic                 in_end_of_line,
  output logic                 cmd_push,
  input  logic                 cmd_space,
  output op_t                  cmd_op,
  output logic [WORD_BITS-1:0] cmd_a,
  output logic [WORD_BITS-1:0] cmd_b
);

  logic [1:0]           tok_r, tok_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic [23:0]          ops_r, ops_nxt;
  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;
  logic                 accept;

  function automatic logic [WORD_BITS-1:0] shift_in(logic [WORD_BITS-1:0] x, logic [7:0] c);
    return (x << 3) + (x << 1) + WORD_BITS'(c) - WORD_BITS'(CH_ZERO);
  endfunction

  assign in_ready = cmd_space;
  assign accept   = in_valid && in_ready;

  always_comb begin
    tok_nxt = tok_r;
    cnt_nxt = cnt_r;
    ops_nxt = ops_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    if (accept) begin
      priority if (in_char_byte == CH_SPACE) begin
        if (tok_r != TOKEN_LAST) tok_nxt = tok_r + 2'd1;
      end else if (tok_r == 2'd0) begin
        if (cnt_r != OP_CHARS_FULL) begin
          unique case (cnt_r)
            2'd0:    ops_nxt[7:0]   = in_char_byte;
            2'd1:    ops_nxt[15:8]  = in_char_byte;
            default: ops_nxt[23:16] = in_char_byte;
          endcase
          cnt_nxt = cnt_r + 2'd1;
        end
      end else if (tok_r == 2'd1) begin
        a_nxt = shift_in(a_r, in_char_byte);
      end else if (tok_r == 2'd2) begin
        b_nxt = shift_in(b_r, in_char_byte);
      end else begin
        // drop bytes of later tokens
      end
    end
  end

  assign cmd_push = accept && in_end_of_line;
  assign cmd_op   = decode_op(cnt_nxt, ops_nxt);
  assign cmd_a    = a_nxt;
  assign cmd_b    = b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd_push) begin
      tok_r <= '0;
      cnt_r <= '0;
      ops_r <= '0;
      a_r   <= '0;
      b_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      cnt_r <= cnt_nxt;
      ops_r <= ops_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
    end
  end

endmodule

// ===== rtl/tcc_queue.sv =====
`timescale 1ns / 1ps
module tcc_queue
  import tcc_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 space,
  input  op_t                  push_op,
  input  logic [WORD_BITS-1:0] push_a,
  input  logic [WORD_BITS-1:0] push_b,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output op_t                  pop_op,
  output logic [WORD_BITS-1:0] pop_a,
  output logic [WORD_BITS-1:0] pop_b
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t                  op_r [DEPTH];
  logic [WORD_BITS-1:0] a_r  [DEPTH];
  logic [WORD_BITS-1:0] b_r  [DEPTH];
  logic [PTR_W-1:0]     wr_r, wr_nxt;
  logic [PTR_W-1:0]     rd_r, rd_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 pop;

  assign space     = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_op    = op_r[rd_r];
  assign pop_a     = a_r[rd_r];
  assign pop_b     = b_r[rd_r];

  function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_nxt  = push ? advance(wr_r) : wr_r;
    rd_nxt  = pop ? advance(rd_r) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_r[wr_r] <= push_op;
      a_r[wr_r]  <= push_a;
      b_r[wr_r]  <= push_b;
    end
  end

endmodule

// ===== rtl/tcc_back.sv =====
`timescale 1ns / 1ps
module tcc_back
  import tcc_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  op_t                  cmd_op,
  input  logic [WORD_BITS-1:0] cmd_a,
  input  logic [WORD_BITS-1:0] cmd_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_answer,
  output logic [1:0]           out_status
);

  localparam int CNT_W = $clog2(WORD_BITS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIX  = 5'b01000,
    S_OUT  = 5'b10000
  } bk_state_t;

  bk_state_t            state_r, state_nxt;
  logic [WORD_BITS:0]   acc_r, acc_nxt;
  logic [WORD_BITS-1:0] x_r, x_nxt;
  logic [WORD_BITS-1:0] y_r, y_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 is_div_r, is_div_nxt;
  logic [WORD_BITS-1:0] res_r, res_nxt;
  logic [1:0]           st_r, st_nxt;
  logic                 ov_r, ov_nxt;
  logic signed [31:0]   ans_r, ans_nxt;
  logic [1:0]           ost_r, ost_nxt;
  logic [WORD_BITS:0]   rem_sh;
  logic                 rem_ge;

  assign cmd_ready  = (state_r == S_IDLE);
  assign out_valid  = ov_r;
  assign out_answer = ans_r;
  assign out_status = ost_r;

  assign rem_sh = {acc_r[WORD_BITS-1:0], x_r[WORD_BITS-1]};
  assign rem_ge = (rem_sh >= {1'b0, y_r});

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    is_div_nxt = is_div_r;
    res_nxt    = res_r;
    st_nxt     = st_r;
    ov_nxt     = ov_r && !out_ready;
    ans_nxt    = ans_r;
    ost_nxt    = ost_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          acc_nxt = '0;
          cnt_nxt = CNT_W'(WORD_BITS - 1);
          st_nxt  = ST_OK;
          res_nxt = '0;
          unique case (cmd_op)
            OP_ADD: begin
              res_nxt   = cmd_a + cmd_b;
              state_nxt = S_OUT;
            end
            OP_SUB: begin
              res_nxt   = cmd_a - cmd_b;
              state_nxt = S_OUT;
            end
            OP_MUL: begin
              x_nxt      = cmd_a;
              y_nxt      = cmd_b;
              is_div_nxt = 1'b0;
              state_nxt  = S_MUL;
            end
            OP_DIV: begin
              if (cmd_b == '0) begin
                st_nxt    = ST_DIV_ZERO;
                state_nxt = S_OUT;
              end else begin
                // divide magnitudes, fix the sign at the end
                x_nxt      = cmd_a[WORD_BITS-1] ? -cmd_a : cmd_a;
                y_nxt      = cmd_b[WORD_BITS-1] ? -cmd_b : cmd_b;
                neg_nxt    = cmd_a[WORD_BITS-1] ^ cmd_b[WORD_BITS-1];
                is_div_nxt = 1'b1;
                state_nxt  = S_DIV;
              end
            end
            default: begin
              st_nxt    = ST_BAD_OP;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_MUL: begin
        acc_nxt = {1'b0, acc_r[WORD_BITS-1:0] + (y_r[0] ? x_r : '0)};
        x_nxt   = x_r << 1;
        y_nxt   = y_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) state_nxt = S_FIX;
      end
      S_DIV: begin
        acc_nxt = rem_ge ? rem_sh - {1'b0, y_r} : rem_sh;
        x_nxt   = {x_r[WORD_BITS-2:0], rem_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) state_nxt = S_FIX;
      end
      S_FIX: begin
        if (is_div_r) res_nxt = neg_r ? -x_r : x_r;
        else          res_nxt = acc_r[WORD_BITS-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ans_nxt   = 32'($signed(res_r));
          ost_nxt   = st_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    is_div_r <= is_div_nxt;
    res_r    <= res_nxt;
    st_r     <= st_nxt;
    ans_r    <= ans_nxt;
    ost_r    <= ost_nxt;
  end

endmodule

// ===== rtl/text_command_calculator.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Word                          Accepted when
// in_ch    in         char_byte[7:0], end_of_line   valid && ready
// out_ch   out        answer[31:0], status[1:0]     valid && ready
//
// The parser takes one byte per cycle; it stalls only while the two-entry
// command queue is full. Add, sub and error lines go from idle straight to
// the output state; mul and div first run the shared one-bit-per-cycle
// shift-add / restoring-divide datapath, then a fix-up state.
// Synchronous active-low reset empties the queue and parser state; no
// clearing pass. The output register lets the executor finish while a result
// waits to be taken.
module text_command_calculator
  import tcc_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  tcc_in_if.sink     in_ch,
  tcc_out_if.source  out_ch
);

  logic                 q_push;
  logic                 q_space;
  op_t                  q_push_op;
  logic [WORD_BITS-1:0] q_push_a;
  logic [WORD_BITS-1:0] q_push_b;
  logic                 q_valid;
  logic                 q_ready;
  op_t                  q_op;
  logic [WORD_BITS-1:0] q_a;
  logic [WORD_BITS-1:0] q_b;

  tcc_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_char_byte   (in_ch.char_byte),
    .in_end_of_line (in_ch.end_of_line),
    .cmd_push       (q_push),
    .cmd_space      (q_space),
    .cmd_op         (q_push_op),
    .cmd_a          (q_push_a),
    .cmd_b          (q_push_b)
  );

  tcc_queue #(.WORD_BITS(WORD_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .space     (q_space),
    .push_op   (q_push_op),
    .push_a    (q_push_a),
    .push_b    (q_push_b),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_op    (q_op),
    .pop_a     (q_a),
    .pop_b     (q_b)
  );

  tcc_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd_op     (q_op),
    .cmd_a      (q_a),
    .cmd_b      (q_b),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_answer (out_ch.answer),
    .out_status (out_ch.status)
  );

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !q_valid)
    else $error("queue or output not empty after reset");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.answer == 32'sd0)
    else $error("error result with nonzero answer");

  a_line_queued: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> q_valid)
    else $error("finished line missing from command queue");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import tcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 60;
  localparam int LONG_HOLD   = 200;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } line_word_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic [1:0]         status;
  } answer_t;

  logic clk;
  logic rst_n;

  tcc_in_if  in_ch ();
  tcc_out_if out_ch ();

  text_command_calculator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  line_word_t line_bytes[$];
  logic [7:0] line_buf[$];
  answer_t    pending_answers[$];

  int words_offered = 0;
  int words_taken   = 0;
  int bytes_queued  = 0;
  int mismatches    = 0;
  int cycle_count   = 0;
  int n_ok = 0, n_bad_op = 0, n_div_zero = 0;

  bit quiet_phase     = 1'b0;
  bit long_stall_req  = 1'b0;
  bit long_stall_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;

  // Parser state of the predictor
  logic [1:0]  tok_idx;
  logic [1:0]  op_cnt;
  logic [23:0] op_word;
  logic [31:0] lhs;
  logic [31:0] rhs;

  task automatic clear_parser();
    tok_idx = '0;
    op_cnt  = '0;
    op_word = '0;
    lhs     = '0;
    rhs     = '0;
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic eol);
    answer_t            res;
    op_t                kind;
    logic signed [63:0] sa, sb, sq;
    if (c == CH_SPACE) begin
      if (tok_idx != TOKEN_LAST) tok_idx = tok_idx + 2'd1;
    end else if (tok_idx == 2'd0) begin
      if (op_cnt != OP_CHARS_FULL) begin
        op_word = op_word | ({16'b0, c} << (8 * op_cnt));
        op_cnt  = op_cnt + 2'd1;
      end
    end else if (tok_idx == 2'd1) begin
      lhs = lhs * 32'd10 + {24'b0, c} - {24'b0, CH_ZERO};
    end else if (tok_idx == 2'd2) begin
      rhs = rhs * 32'd10 + {24'b0, c} - {24'b0, CH_ZERO};
    end
    if (eol) begin
      kind = OP_BAD;
      if (op_cnt == OP_CHARS_FULL) begin
        case (op_word)
          OPS_ADD: kind = OP_ADD;
          OPS_SUB: kind = OP_SUB;
          OPS_MUL: kind = OP_MUL;
          OPS_DIV: kind = OP_DIV;
          default: kind = OP_BAD;
        endcase
      end
      res.answer = '0;
      res.status = ST_OK;
      case (kind)
        OP_ADD: res.answer = lhs + rhs;
        OP_SUB: res.answer = lhs - rhs;
        OP_MUL: res.answer = lhs * rhs;
        OP_DIV: begin
          if (rhs == '0) begin
            res.status = ST_DIV_ZERO;
          end else begin
            // widen so that the most negative value over -1 wraps back
            sa = {{32{lhs[31]}}, lhs};
            sb = {{32{rhs[31]}}, rhs};
            sq = sa / sb;
            res.answer = sq[31:0];
          end
        end
        default: res.status = ST_BAD_OP;
      endcase
      pending_answers.push_back(res);
      clear_parser();
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_number(input logic [31:0] v);
    logic [7:0]  dig [0:9];
    logic [31:0] t, r;
    int          n;
    n = 0;
    t = v;
    do begin
      r = t % 10;
      dig[n] = CH_ZERO + r[7:0];
      t = t / 10;
      n++;
    end while (t != 0);
    for (int i = n - 1; i >= 0; i--) line_buf.push_back(dig[i]);
  endtask

  task automatic flush_line();
    line_word_t w;
    while (line_buf.size() > 0) begin
      w.char_byte   = line_buf.pop_front();
      w.end_of_line = (line_buf.size() == 0);
      line_bytes.push_back(w);
      bytes_queued++;
    end
  endtask

  task automatic add_operand();
    logic [7:0]  b;
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: ;  // empty token
      1, 2, 3, 4: add_number($urandom_range(0, 999));
      5, 6: add_number($urandom);
      7: begin
        // more digits than fit, value wraps
        repeat ($urandom_range(11, 16)) begin
          b = CH_ZERO + 8'($urandom_range(0, 9));
          line_buf.push_back(b);
        end
      end
      8: begin
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom);
          line_buf.push_back(b);
        end
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hffff_ffff;
          3: v = 32'h8000_0000;
          default: v = 32'h7fff_ffff;
        endcase
        add_number(v);
      end
    endcase
  endtask

  task automatic queue_random_line();
    logic [7:0] b;
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 9))
        0, 1: add_text("add");
        2, 3: add_text("sub");
        4, 5: add_text("mul");
        6, 7: add_text("div");
        8: begin
          repeat ($urandom_range(0, 5)) begin
            b = 8'($urandom_range(33, 126));
            line_buf.push_back(b);
          end
        end
        default: begin
          case ($urandom_range(0, 3))
            0: add_text("ad");
            1: add_text("divide");
            2: add_text("mux");
            default: add_text("sbu");
          endcase
        end
      endcase
      line_buf.push_back(CH_SPACE);
      if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_SPACE);
      add_operand();
      if ($urandom_range(0, 9) != 0) begin
        line_buf.push_back(CH_SPACE);
        add_operand();
      end
      if ($urandom_range(0, 7) == 0) begin
        line_buf.push_back(CH_SPACE);
        add_operand();
      end
      if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_SPACE);
    end else begin
      repeat ($urandom_range(1, 20)) begin
        b = 8'($urandom);
        if ($urandom_range(0, 3) == 0) b = CH_SPACE;
        line_buf.push_back(b);
      end
    end
    flush_line();
  endtask

  task automatic wait_drained();
    while (line_bytes.size() != 0 || words_offered != words_taken ||
           pending_answers.size() != 0)
      @(negedge clk);
  endtask

  // Sender: present a word at the falling edge, hold it until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && words_offered != words_taken) begin
      // hold
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap--;
    end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      send_gap = $urandom_range(0, 2);
    end else if (line_bytes.size() > 0) begin
      in_ch.valid       <= 1'b1;
      in_ch.char_byte   <= line_bytes[0].char_byte;
      in_ch.end_of_line <= line_bytes[0].end_of_line;
      words_offered++;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (long_stall_req && !long_stall_done) begin
        hold_left = LONG_HOLD;
        long_stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (recv_gap > 0) begin
        out_ch.ready <= 1'b0;
        recv_gap--;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        recv_gap = $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.char_byte, in_ch.end_of_line);
        void'(line_bytes.pop_front());
        words_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result, expected none, got answer %0d status %0d",
                   $time, out_ch.answer, out_ch.status);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          if (out_ch.answer !== want.answer) begin
            $display("%0t: answer mismatch, expected %0d, got %0d",
                     $time, want.answer, out_ch.answer);
            mismatches++;
          end
          if (out_ch.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_ch.status);
            mismatches++;
          end
          case (want.status)
            ST_OK:     n_ok++;
            ST_BAD_OP: n_bad_op++;
            default:   n_div_zero++;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_answers.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.char_byte   = '0;
    in_ch.end_of_line = 1'b0;
    out_ch.ready      = 1'b0;
    clear_parser();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed lines
    add_text("add 12 34");                  flush_line();
    add_text("sub 5 9");                    flush_line();
    add_text("mul 99 99");                  flush_line();
    add_text("div 4294967289 2");           flush_line();
    add_text("div 2147483648 4294967295");  flush_line();
    add_text("div 5 0");                    flush_line();
    add_text("div 5");                      flush_line();
    add_text("ad 1 2");                     flush_line();
    add_text("xyz 1 2");                    flush_line();
    add_text("addx 1 2");                   flush_line();
    add_text("add  3 4");                   flush_line();
    add_text("add 1 2 3 4");                flush_line();
    add_text("sub ");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hff);
    add_text(" 1");                         flush_line();
    add_text("m");                          flush_line();
    add_text("mul 7 ");                     flush_line();
    wait_drained();

    // Random lines; stall the receiver once while the sender keeps pushing
    while (bytes_queued < 500) queue_random_line();
    long_stall_req = 1'b1;
    while (bytes_queued < 800) queue_random_line();
    wait_drained();

    // Back-to-back traffic to the end
    quiet_phase = 1'b1;
    while (bytes_queued < 1150) queue_random_line();
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d bytes; checked %0d ok, %0d unknown op, %0d divide-by-zero lines",
             words_taken, n_ok, n_bad_op, n_div_zero);
    $display("Receiver held off %0d cycles once; %0d mismatches", LONG_HOLD, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
